>>> hdl/rau_pkg.sv
`timescale 1ns / 1ps

package rau_pkg;

  localparam int FIELD_W  = 32;
  localparam int DEN_W    = 31;
  localparam int KIND_W   = 4;
  localparam int STATUS_W = 2;

  localparam logic [KIND_W-1:0] KIND_ADD = 4'd0;
  localparam logic [KIND_W-1:0] KIND_SUB = 4'd1;
  localparam logic [KIND_W-1:0] KIND_MUL = 4'd2;
  localparam logic [KIND_W-1:0] KIND_DIV = 4'd3;
  localparam logic [KIND_W-1:0] KIND_LT  = 4'd4;
  localparam logic [KIND_W-1:0] KIND_LE  = 4'd5;
  localparam logic [KIND_W-1:0] KIND_GT  = 4'd6;
  localparam logic [KIND_W-1:0] KIND_GE  = 4'd7;
  localparam logic [KIND_W-1:0] KIND_EQ  = 4'd8;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL0,
    OP_MUL1,
    OP_MUL2,
    OP_COMBINE,
    OP_GCD,
    OP_GCD_FIN,
    OP_DIV,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic skip;      // unknown kind, zero denominator or compare: no reduction
    logic num_zero;  // arithmetic numerator is zero
    logic gcd_done;
    logic div_last;
    logic out_busy;  // result register full and stalled
  } sts_t;

endpackage

>>> hdl/rau_ctrl.sv
`timescale 1ns / 1ps

module rau_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  rau_pkg::sts_t sts,
  output rau_pkg::cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MUL0 = 8'b0000_0010,
    S_MUL1 = 8'b0000_0100,
    S_MUL2 = 8'b0000_1000,
    S_COMB = 8'b0001_0000,
    S_GCD  = 8'b0010_0000,
    S_DIV  = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = rau_pkg::OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = rau_pkg::OP_LOAD;
          state_nxt = S_MUL0;
        end
      end
      S_MUL0: begin
        cmd.op    = rau_pkg::OP_MUL0;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.op    = rau_pkg::OP_MUL1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.op    = rau_pkg::OP_MUL2;
        state_nxt = S_COMB;
      end
      S_COMB: begin
        if (sts.skip || sts.num_zero) begin
          state_nxt = S_FIN;
        end else begin
          cmd.op    = rau_pkg::OP_COMBINE;
          state_nxt = S_GCD;
        end
      end
      S_GCD: begin
        if (sts.gcd_done) begin
          cmd.op    = rau_pkg::OP_GCD_FIN;
          state_nxt = S_DIV;
        end else begin
          cmd.op = rau_pkg::OP_GCD;
        end
      end
      S_DIV: begin
        cmd.op = rau_pkg::OP_DIV;
        if (sts.div_last) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.op    = rau_pkg::OP_FINISH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_MUL0))
    else $error("accepted request did not start the multiply sequence");

  a_fin_only_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == rau_pkg::OP_FINISH) |=> (state_r == S_IDLE))
    else $error("controller did not return to idle after finishing");

  a_div_after_gcd: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == S_DIV) |-> ($past(state_r) == S_GCD))
    else $error("division entered without a completed gcd");

endmodule

>>> hdl/rau_dp.sv
`timescale 1ns / 1ps

module rau_dp #(
  parameter int WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rau_pkg::cmd_t                       cmd,
  output rau_pkg::sts_t                       sts,
  input  logic [rau_pkg::KIND_W-1:0]          in_kind,
  input  logic [rau_pkg::FIELD_W-1:0]         in_a_num,
  input  logic [rau_pkg::FIELD_W-1:0]         in_a_den,
  input  logic [rau_pkg::FIELD_W-1:0]         in_b_num,
  input  logic [rau_pkg::FIELD_W-1:0]         in_b_den,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [rau_pkg::FIELD_W-1:0]  out_res_num,
  output logic [rau_pkg::DEN_W-1:0]           out_res_den,
  output logic                                out_cmp_true,
  output logic [rau_pkg::STATUS_W-1:0]        out_status
);

  localparam int DW = 2 * WIDTH;
  localparam int KW = $clog2(DW + 1);
  localparam int CW = $clog2(DW);
  localparam logic [DW-1:0] LIM = {{(DW-1){1'b0}}, 1'b1} << (WIDTH - 1);

  // operand decode
  logic [WIDTH-1:0] an_v, ad_v, bn_v, bd_v;
  logic [WIDTH-1:0] an_m, ad_m, bn_m, bd_m;
  logic             kind_known;

  assign an_v = in_a_num[WIDTH-1:0];
  assign ad_v = in_a_den[WIDTH-1:0];
  assign bn_v = in_b_num[WIDTH-1:0];
  assign bd_v = in_b_den[WIDTH-1:0];
  assign an_m = an_v[WIDTH-1] ? (~an_v + 1'b1) : an_v;
  assign ad_m = ad_v[WIDTH-1] ? (~ad_v + 1'b1) : ad_v;
  assign bn_m = bn_v[WIDTH-1] ? (~bn_v + 1'b1) : bn_v;
  assign bd_m = bd_v[WIDTH-1] ? (~bd_v + 1'b1) : bd_v;
  assign kind_known = (in_kind <= rau_pkg::KIND_EQ);

  logic [rau_pkg::KIND_W-1:0] kind_r;
  logic                       unknown_r, err_r, an_neg_r, bn_neg_r;
  logic [WIDTH-1:0]           an_r, ad_r, bn_r, bd_r;
  logic [DW-1:0]              l_r, r_r, den_r;
  logic [DW-1:0]              u_r, v_r, g_r, num_mag_r;
  logic [DW-1:0]              nq_r, dq_r, nrem_r, drem_r;
  logic [KW-1:0]              k_r;
  logic [CW-1:0]              cnt_r;
  logic                       num_neg_r;
  logic                       out_valid_r;

  logic is_cmp, is_sub, is_muldiv;
  assign is_cmp    = (kind_r >= rau_pkg::KIND_LT);
  assign is_sub    = (kind_r == rau_pkg::KIND_SUB);
  assign is_muldiv = (kind_r == rau_pkg::KIND_MUL) || (kind_r == rau_pkg::KIND_DIV);

  // shared multiplier, one product per step
  logic [WIDTH-1:0] mul_x, mul_y;
  logic [DW-1:0]    prod;

  always_comb begin
    mul_x = an_r;
    mul_y = bd_r;
    unique case (cmd.op)
      rau_pkg::OP_MUL0: begin
        mul_x = an_r;
        mul_y = (kind_r == rau_pkg::KIND_MUL) ? bn_r : bd_r;
      end
      rau_pkg::OP_MUL1: begin
        mul_x = bn_r;
        mul_y = ad_r;
      end
      rau_pkg::OP_MUL2: begin
        mul_x = ad_r;
        mul_y = (kind_r == rau_pkg::KIND_DIV) ? bn_r : bd_r;
      end
      default: ;
    endcase
  end

  assign prod = DW'(mul_x) * DW'(mul_y);

  // signed-magnitude combine of the cross products
  logic          r_neg, l_ge_r;
  logic [DW-1:0] num_mag_c;
  logic          num_neg_c;

  assign r_neg  = (bn_neg_r ^ is_sub) && (r_r != '0);
  assign l_ge_r = (l_r >= r_r);

  always_comb begin
    if (is_muldiv) begin
      num_mag_c = l_r;
      num_neg_c = an_neg_r ^ bn_neg_r;
    end else if (an_neg_r == r_neg) begin
      num_mag_c = l_r + r_r;
      num_neg_c = an_neg_r;
    end else if (l_ge_r) begin
      num_mag_c = l_r - r_r;
      num_neg_c = an_neg_r;
    end else begin
      num_mag_c = r_r - l_r;
      num_neg_c = r_neg;
    end
  end

  // exact compare: l = a_num*b_den, r = b_num*a_den, signs already on numerators
  logic c_lt, c_eq, cmp_c;
  assign c_eq = (an_neg_r == bn_neg_r) && (l_r == r_r);
  assign c_lt = (an_neg_r && !bn_neg_r) ||
                ((an_neg_r == bn_neg_r) && (an_neg_r ? (l_r > r_r) : (l_r < r_r)));

  always_comb begin
    unique case (kind_r)
      rau_pkg::KIND_LT: cmp_c = c_lt;
      rau_pkg::KIND_LE: cmp_c = c_lt || c_eq;
      rau_pkg::KIND_GT: cmp_c = !c_lt && !c_eq;
      rau_pkg::KIND_GE: cmp_c = !c_lt;
      default:          cmp_c = c_eq;
    endcase
  end

  // binary gcd step
  logic [DW-1:0] u_nxt, v_nxt;
  logic [KW-1:0] k_nxt;

  always_comb begin
    u_nxt = u_r;
    v_nxt = v_r;
    k_nxt = k_r;
    priority if (!u_r[0] && !v_r[0]) begin
      u_nxt = u_r >> 1;
      v_nxt = v_r >> 1;
      k_nxt = k_r + 1'b1;
    end else if (!u_r[0]) begin
      u_nxt = u_r >> 1;
    end else if (!v_r[0]) begin
      v_nxt = v_r >> 1;
    end else if (u_r >= v_r) begin
      u_nxt = u_r - v_r;
    end else begin
      v_nxt = v_r - u_r;
    end
  end

  // restoring divide of numerator and denominator by the gcd, one bit a cycle
  logic [DW:0]   n_trial, d_trial;
  logic          n_bit, d_bit;
  logic [DW-1:0] nrem_nxt, drem_nxt;

  assign n_trial  = {nrem_r, nq_r[DW-1]};
  assign d_trial  = {drem_r, dq_r[DW-1]};
  assign n_bit    = (n_trial >= {1'b0, g_r});
  assign d_bit    = (d_trial >= {1'b0, g_r});
  assign nrem_nxt = n_bit ? DW'(n_trial - {1'b0, g_r}) : DW'(n_trial);
  assign drem_nxt = d_bit ? DW'(d_trial - {1'b0, g_r}) : DW'(d_trial);

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      rau_pkg::OP_LOAD: begin
        kind_r    <= in_kind;
        unknown_r <= !kind_known;
        err_r     <= (ad_m == '0) || (bd_m == '0) ||
                     ((in_kind == rau_pkg::KIND_DIV) && (bn_m == '0));
        an_neg_r  <= (an_v[WIDTH-1] ^ ad_v[WIDTH-1]) && (an_m != '0);
        bn_neg_r  <= (bn_v[WIDTH-1] ^ bd_v[WIDTH-1]) && (bn_m != '0);
        an_r      <= an_m;
        ad_r      <= ad_m;
        bn_r      <= bn_m;
        bd_r      <= bd_m;
      end
      rau_pkg::OP_MUL0: l_r   <= prod;
      rau_pkg::OP_MUL1: r_r   <= prod;
      rau_pkg::OP_MUL2: den_r <= prod;
      rau_pkg::OP_COMBINE: begin
        num_mag_r <= num_mag_c;
        num_neg_r <= num_neg_c;
        u_r       <= num_mag_c;
        v_r       <= den_r;
        k_r       <= '0;
      end
      rau_pkg::OP_GCD: begin
        u_r <= u_nxt;
        v_r <= v_nxt;
        k_r <= k_nxt;
      end
      rau_pkg::OP_GCD_FIN: begin
        g_r    <= ((u_r == '0) ? v_r : u_r) << k_r;
        nq_r   <= num_mag_r;
        dq_r   <= den_r;
        nrem_r <= '0;
        drem_r <= '0;
        cnt_r  <= '0;
      end
      rau_pkg::OP_DIV: begin
        nrem_r <= nrem_nxt;
        drem_r <= drem_nxt;
        nq_r   <= {nq_r[DW-2:0], n_bit};
        dq_r   <= {dq_r[DW-2:0], d_bit};
        cnt_r  <= cnt_r + 1'b1;
      end
      default: ;
    endcase
  end

  // result selection
  logic                               ovf;
  logic [rau_pkg::FIELD_W-1:0]        q_num_ext;
  logic signed [rau_pkg::FIELD_W-1:0] res_num_c;
  logic [rau_pkg::DEN_W-1:0]          res_den_c;
  logic                               res_cmp_c;
  logic [rau_pkg::STATUS_W-1:0]       res_st_c;

  assign ovf = (dq_r >= LIM) || (num_neg_r ? (nq_r > LIM) : (nq_r >= LIM));
  assign q_num_ext = rau_pkg::FIELD_W'(nq_r);

  always_comb begin
    res_num_c = '0;
    res_den_c = '0;
    res_cmp_c = 1'b0;
    res_st_c  = rau_pkg::ST_OK;
    priority if (unknown_r) begin
      res_st_c = rau_pkg::ST_OK;
    end else if (err_r) begin
      res_st_c = rau_pkg::ST_ZERO_DEN;
    end else if (is_cmp) begin
      res_cmp_c = cmp_c;
    end else if (num_mag_c == '0) begin
      res_den_c = rau_pkg::DEN_W'(1);
    end else if (ovf) begin
      res_st_c = rau_pkg::ST_OVERFLOW;
    end else begin
      res_num_c = num_neg_r ? (~q_num_ext + 1'b1) : q_num_ext;
      res_den_c = rau_pkg::DEN_W'(dq_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == rau_pkg::OP_FINISH) begin
      out_res_num  <= res_num_c;
      out_res_den  <= res_den_c;
      out_cmp_true <= res_cmp_c;
      out_status   <= res_st_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == rau_pkg::OP_FINISH) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  assign sts.skip     = unknown_r || err_r || is_cmp;
  assign sts.num_zero = (num_mag_c == '0);
  assign sts.gcd_done = (u_r == '0) || (v_r == '0);
  assign sts.div_last = (cnt_r == CW'(DW - 1));
  assign sts.out_busy = out_valid_r && out_stall;

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == rau_pkg::OP_DIV) |-> (g_r != '0))
    else $error("division by a zero gcd");

  a_gcd_operands: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == rau_pkg::OP_GCD) |-> ((u_r != '0) && (v_r != '0)))
    else $error("gcd step on a finished pair");

  a_odd_sub_even: assert property (@(posedge clk) disable iff (!rst_n)
    ((cmd.op == rau_pkg::OP_GCD) && u_r[0] && v_r[0]) |=> (!u_r[0] || !v_r[0]))
    else $error("gcd subtract left both operands odd");

  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == rau_pkg::OP_FINISH) |=> out_valid_r)
    else $error("finished request not presented");

endmodule

>>> hdl/rational_arithmetic_unit.sv
`timescale 1ns / 1ps

// Rational arithmetic unit: adds, subtracts, multiplies, divides or compares two
// signed fractions of WIDTH-bit components and returns one result per request,
// reduced by the gcd with a positive denominator. One request is processed at a
// time; in_stall is low only while the block is idle. A compare, an unknown kind
// or a zero denominator goes through three shared multiplier steps and the combine
// state to the result load, which waits while the output is full and stalled. A
// nonzero arithmetic result adds the binary gcd loop, one step per cycle over the
// 2*WIDTH-bit cross products, then the bit-serial restoring divide of numerator
// and denominator by the gcd. The result sits in an output register, so the next
// request is taken while a finished one waits.
module rational_arithmetic_unit #(
  parameter int WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rau_pkg::KIND_W-1:0]          in_kind,
  input  logic signed [rau_pkg::FIELD_W-1:0]  in_a_num,
  input  logic signed [rau_pkg::FIELD_W-1:0]  in_a_den,
  input  logic signed [rau_pkg::FIELD_W-1:0]  in_b_num,
  input  logic signed [rau_pkg::FIELD_W-1:0]  in_b_den,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [rau_pkg::FIELD_W-1:0]  out_res_num,
  output logic [rau_pkg::DEN_W-1:0]           out_res_den,
  output logic                                out_cmp_true,
  output logic [rau_pkg::STATUS_W-1:0]        out_status
);

  rau_pkg::cmd_t cmd;
  rau_pkg::sts_t sts;

  rau_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rau_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_kind      (in_kind),
    .in_a_num     (in_a_num),
    .in_a_den     (in_a_den),
    .in_b_num     (in_b_num),
    .in_b_den     (in_b_den),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_res_num  (out_res_num),
    .out_res_den  (out_res_den),
    .out_cmp_true (out_cmp_true),
    .out_status   (out_status)
  );

endmodule
